FILE: src/arithmetic_subsequence_counter_assert.svh
// Assertion macros for the arithmetic subsequence counter checker.
// Needs clk and rst in the scope of the module that uses them.
`ifndef ARITHMETIC_SUBSEQUENCE_COUNTER_ASSERT_SVH
`define ARITHMETIC_SUBSEQUENCE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ASC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asc checker: property failed");

// Next-cycle implication, disabled while in reset.
`define ASC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asc checker: property failed");

`endif

FILE: src/asc_pkg.sv
// Shared types, sizes, microcode table and modular adder for the subsequence counter.
// No dependencies.
`timescale 1ns / 1ps

package asc_pkg;

  localparam int MAX_ELEMENTS  = 64;
  localparam int VALUE_MAX     = 255;
  localparam int DIFF_SPAN     = 2 * VALUE_MAX + 1;
  localparam int ELEM_W        = 8;
  localparam int MOD_W         = 30;
  localparam int VAL_W         = $clog2(VALUE_MAX + 1);
  localparam int DIFF_W        = $clog2(DIFF_SPAN);
  localparam int IDX_W         = $clog2(MAX_ELEMENTS);
  localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W        = IDX_W + DIFF_W;
  localparam int TABLE_DEPTH   = 1 << ADDR_W;
  localparam int EPOCH_W       = 8;
  localparam int PC_W          = 4;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 30'd100001;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_ROW,
    OP_HEAD,
    OP_PAIR,
    OP_EXT,
    OP_ACC,
    OP_NEXT,
    OP_EMIT,
    OP_CLEAR,
    OP_ARM
  } micro_op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_LAST,
    COND_J_GE_N,
    COND_J1_LT_N,
    COND_I_NZ,
    COND_OUT_BUSY,
    COND_NO_WRAP,
    COND_CLR_BUSY
  } jump_cond_t;

  typedef struct packed {
    micro_op_t  op;
    jump_cond_t cond;
    pc_t        target;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic j_ge_n;
    logic j1_lt_n;
    logic i_nz;
    logic out_busy;
    logic wrap;
    logic clr_busy;
  } seq_status_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [MOD_W-1:0]   value;
  } entry_t;

  localparam pc_t STEP_IDLE = 4'd0;
  localparam pc_t STEP_INIT = 4'd1;
  localparam pc_t STEP_ROW  = 4'd2;
  localparam pc_t STEP_HEAD = 4'd3;
  localparam pc_t STEP_PAIR = 4'd4;
  localparam pc_t STEP_EXT  = 4'd5;
  localparam pc_t STEP_ACC  = 4'd6;
  localparam pc_t STEP_NEXT = 4'd7;
  localparam pc_t STEP_WAIT = 4'd8;
  localparam pc_t STEP_EMIT = 4'd9;
  localparam pc_t STEP_CLR  = 4'd10;
  localparam pc_t STEP_ARM  = 4'd11;

  // Microprogram: jump to target when cond holds, else fall through.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_IDLE: w = '{op: OP_LOAD,  cond: COND_NO_LAST,  target: STEP_IDLE};
      STEP_INIT: w = '{op: OP_INIT,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ROW:  w = '{op: OP_ROW,   cond: COND_NEVER,    target: STEP_IDLE};
      STEP_HEAD: w = '{op: OP_HEAD,  cond: COND_J_GE_N,   target: STEP_NEXT};
      STEP_PAIR: w = '{op: OP_PAIR,  cond: COND_NEVER,    target: STEP_IDLE};
      STEP_EXT:  w = '{op: OP_EXT,   cond: COND_NEVER,    target: STEP_IDLE};
      STEP_ACC:  w = '{op: OP_ACC,   cond: COND_J1_LT_N,  target: STEP_PAIR};
      STEP_NEXT: w = '{op: OP_NEXT,  cond: COND_I_NZ,     target: STEP_ROW};
      STEP_WAIT: w = '{op: OP_NOP,   cond: COND_OUT_BUSY, target: STEP_WAIT};
      STEP_EMIT: w = '{op: OP_EMIT,  cond: COND_NO_WRAP,  target: STEP_IDLE};
      STEP_CLR:  w = '{op: OP_CLEAR, cond: COND_CLR_BUSY, target: STEP_CLR};
      STEP_ARM:  w = '{op: OP_ARM,   cond: COND_ALWAYS,   target: STEP_IDLE};
      default:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_CLR};
    endcase
    return w;
  endfunction

  // a + b reduced by m, for a and b already below m.
  function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_W-1:0];
  endfunction

endpackage

FILE: src/asc_sequencer.sv
// Step counter and microcode table that drive the subsequence counter datapath.
// Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  asc_pkg::seq_status_t status,
  output asc_pkg::micro_op_t  op
);

  asc_pkg::pc_t        pc;
  asc_pkg::pc_t        pc_next;
  asc_pkg::ctrl_word_t word;
  logic                take;

  assign word = asc_pkg::ucode(pc);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      asc_pkg::COND_NEVER:    take = 1'b0;
      asc_pkg::COND_ALWAYS:   take = 1'b1;
      asc_pkg::COND_NO_LAST:  take = !status.start;
      asc_pkg::COND_J_GE_N:   take = status.j_ge_n;
      asc_pkg::COND_J1_LT_N:  take = status.j1_lt_n;
      asc_pkg::COND_I_NZ:     take = status.i_nz;
      asc_pkg::COND_OUT_BUSY: take = status.out_busy;
      asc_pkg::COND_NO_WRAP:  take = !status.wrap;
      asc_pkg::COND_CLR_BUSY: take = status.clr_busy;
      default:                take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + asc_pkg::pc_t'(1);
  end

  // Start with a sweep of the table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= asc_pkg::STEP_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: src/asc_datapath.sv
// Datapath: element store, progression table memory, modular adders, loop indices.
// Depends on asc_pkg; driven by the op code from asc_sequencer.
`timescale 1ns / 1ps

module asc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  asc_pkg::micro_op_t                  op,
  output asc_pkg::seq_status_t                status,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [asc_pkg::ELEM_W-1:0]          element_value,
  input  logic                                is_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [asc_pkg::MOD_W-1:0]           subsequence_count,
  input  logic                                cfg_write,
  input  logic [asc_pkg::MOD_W-1:0]           cfg_data
);

  logic [asc_pkg::MOD_W-1:0]    modulus;
  logic [asc_pkg::MOD_W-1:0]    m_eff;
  logic [asc_pkg::CNT_W-1:0]    n;
  logic [asc_pkg::IDX_W-1:0]    i;
  logic [asc_pkg::CNT_W-1:0]    j;
  logic [asc_pkg::CNT_W-1:0]    j_inc;
  logic [asc_pkg::VAL_W-1:0]    vi;
  logic [asc_pkg::DIFF_W-1:0]   k;
  logic [asc_pkg::DIFF_W-1:0]   k_pair;
  logic [asc_pkg::MOD_W-1:0]    ext;
  logic [asc_pkg::MOD_W-1:0]    ext_next;
  logic [asc_pkg::MOD_W-1:0]    total;
  logic [asc_pkg::MOD_W-1:0]    total_plus_one;
  logic [asc_pkg::MOD_W-1:0]    total_plus_ext;
  logic [asc_pkg::MOD_W-1:0]    ti_new;
  logic [asc_pkg::MOD_W-1:0]    tj_val;
  logic [asc_pkg::MOD_W-1:0]    ti_val;
  logic [asc_pkg::MOD_W-1:0]    result;
  logic [asc_pkg::EPOCH_W-1:0]  epoch;
  logic [asc_pkg::ADDR_W-1:0]   clr_addr;
  logic [asc_pkg::VAL_W-1:0]    sat_value;
  logic                         load_fire;

  logic [asc_pkg::VAL_W-1:0]    elem_store [asc_pkg::MAX_ELEMENTS];
  logic [asc_pkg::VAL_W-1:0]    elem_q;
  logic [asc_pkg::IDX_W-1:0]    elem_rd_addr;

  asc_pkg::entry_t              table_mem [asc_pkg::TABLE_DEPTH];
  asc_pkg::entry_t              tj_q;
  asc_pkg::entry_t              ti_q;
  asc_pkg::entry_t              wr_data;
  logic [asc_pkg::ADDR_W-1:0]   rd_addr_a;
  logic [asc_pkg::ADDR_W-1:0]   rd_addr_b;
  logic [asc_pkg::ADDR_W-1:0]   wr_addr;
  logic                         wr_en;

  assign in_stall          = (op != asc_pkg::OP_LOAD);
  assign load_fire         = in_valid && (op == asc_pkg::OP_LOAD);
  assign subsequence_count = result;
  assign sat_value = (32'(element_value) > 32'(asc_pkg::VALUE_MAX)) ?
                     asc_pkg::VAL_W'(asc_pkg::VALUE_MAX) : asc_pkg::VAL_W'(element_value);

  // Entries tagged by an older sequence read as zero.
  assign tj_val = (tj_q.tag == epoch) ? tj_q.value : '0;
  assign ti_val = (ti_q.tag == epoch) ? ti_q.value : '0;

  assign j_inc          = j + asc_pkg::CNT_W'(1);
  assign k_pair         = asc_pkg::DIFF_W'(elem_q) + asc_pkg::DIFF_W'(asc_pkg::VALUE_MAX)
                          - asc_pkg::DIFF_W'(vi);
  assign ext_next       = asc_pkg::mod_add(tj_val, asc_pkg::MOD_W'(1), m_eff);
  assign ti_new         = asc_pkg::mod_add(ti_val, ext, m_eff);
  assign total_plus_ext = asc_pkg::mod_add(total, ext, m_eff);
  assign total_plus_one = asc_pkg::mod_add(total, asc_pkg::MOD_W'(1), m_eff);

  assign rd_addr_a = {j[asc_pkg::IDX_W-1:0], k_pair};
  assign rd_addr_b = {i, k_pair};
  assign wr_en     = (op == asc_pkg::OP_ACC) || (op == asc_pkg::OP_CLEAR);
  assign wr_addr   = (op == asc_pkg::OP_CLEAR) ? clr_addr : {i, k};
  assign wr_data   = (op == asc_pkg::OP_CLEAR) ? asc_pkg::entry_t'('0) :
                     asc_pkg::entry_t'{tag: epoch, value: ti_new};

  always_comb begin
    case (op)
      asc_pkg::OP_ROW: elem_rd_addr = i;
      asc_pkg::OP_ACC: elem_rd_addr = j_inc[asc_pkg::IDX_W-1:0];
      default:         elem_rd_addr = j[asc_pkg::IDX_W-1:0];
    endcase
  end

  always_comb begin
    status.start    = load_fire && is_last;
    status.j_ge_n   = (j >= n);
    status.j1_lt_n  = (j_inc < n);
    status.i_nz     = (i != '0);
    status.out_busy = out_valid && out_stall;
    status.wrap     = &epoch;
    status.clr_busy = !(&clr_addr);
  end

  // Element store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (load_fire && (n < asc_pkg::CNT_W'(asc_pkg::MAX_ELEMENTS))) begin
      elem_store[n[asc_pkg::IDX_W-1:0]] <= sat_value;
    end
    elem_q <= elem_store[elem_rd_addr];
  end

  // Progression table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (op == asc_pkg::OP_PAIR) begin
      tj_q <= table_mem[rd_addr_a];
      ti_q <= table_mem[rd_addr_b];
    end
  end

  // Working registers, no reset.
  always_ff @(posedge clk) begin
    case (op)
      asc_pkg::OP_INIT: begin
        m_eff <= (modulus == '0) ? asc_pkg::MOD_W'(1) : modulus;
        total <= (modulus <= asc_pkg::MOD_W'(1)) ? '0 : asc_pkg::MOD_W'(1);
        i     <= asc_pkg::IDX_W'(n - asc_pkg::CNT_W'(1));
      end
      asc_pkg::OP_ROW: begin
        total <= total_plus_one;
        j     <= asc_pkg::CNT_W'(i) + asc_pkg::CNT_W'(1);
      end
      asc_pkg::OP_HEAD: vi <= elem_q;
      asc_pkg::OP_PAIR: k <= k_pair;
      asc_pkg::OP_EXT:  ext <= ext_next;
      asc_pkg::OP_ACC: begin
        total <= total_plus_ext;
        j     <= j_inc;
      end
      asc_pkg::OP_NEXT: begin
        if (i != '0) begin
          i <= i - asc_pkg::IDX_W'(1);
        end
      end
      asc_pkg::OP_EMIT: result <= total;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= asc_pkg::MODULUS_RESET;
      n         <= '0;
      epoch     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        modulus <= cfg_data;
      end
      if (load_fire && (n < asc_pkg::CNT_W'(asc_pkg::MAX_ELEMENTS))) begin
        n <= n + asc_pkg::CNT_W'(1);
      end
      if (op == asc_pkg::OP_CLEAR) begin
        clr_addr <= clr_addr + asc_pkg::ADDR_W'(1);
      end
      if (op == asc_pkg::OP_ARM) begin
        epoch <= asc_pkg::EPOCH_W'(1);
      end
      if (op == asc_pkg::OP_EMIT) begin
        n         <= '0;
        epoch     <= epoch + asc_pkg::EPOCH_W'(1);
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/arithmetic_subsequence_counter.sv
// Elements are taken while in_stall is low; after the flagged last element the count for
// n held elements is computed row by row, mostly by the three-step pair loop (PAIR, EXT,
// ACC) on the table memory.
// Reset: synchronous; modulus returns to 100001, then a sweep that clears the whole table runs
// with in_stall high. The same sweep follows every 255th sequence.
`timescale 1ns / 1ps

module arithmetic_subsequence_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [asc_pkg::ELEM_W-1:0] element_value,
  input  logic                       is_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [asc_pkg::MOD_W-1:0]  subsequence_count,
  input  logic                       cfg_write,
  input  logic [asc_pkg::MOD_W-1:0]  cfg_data
);

  asc_pkg::micro_op_t   op;
  asc_pkg::seq_status_t status;

  asc_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  asc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .status            (status),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .element_value     (element_value),
    .is_last           (is_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .subsequence_count (subsequence_count),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data)
  );

endmodule

FILE: src/asc_checker.sv
// Port-level checker for the subsequence counter, bound to the top level.
// Depends on arithmetic_subsequence_counter_assert.svh and asc_pkg.
`timescale 1ns / 1ps
`include "arithmetic_subsequence_counter_assert.svh"

module asc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       is_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [asc_pkg::MOD_W-1:0]  subsequence_count
);

  // Hold a stalled result.
  `ASC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(subsequence_count))
  // Stop taking requests once the last element has gone in.
  `ASC_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && is_last, in_stall)
  // A result is only raised from a busy cycle.
  `ASC_ASSERT_NOW(a_emit_busy, $rose(out_valid), $past(in_stall))
  // No two results on consecutive cycles.
  `ASC_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid)

endmodule

bind arithmetic_subsequence_counter asc_checker u_checker (.*);
